### src/smgd_pkg.sv
// smgd_pkg: shared types and constants for the serial mouse gesture decoder.
// No dependencies; used by smgd_front, smgd_queue, smgd_back and the core.
package smgd_pkg;

  localparam logic [7:0] SYNC_BIT   = 8'h40;
  localparam logic [7:0] X_HI_MASK  = 8'h03;
  localparam logic [7:0] LOW6_MASK  = 8'h3F;
  localparam logic [7:0] Y_HI_MASK  = 8'h0C;
  localparam logic [7:0] RIGHT_MASK = 8'h10;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned THRESH_W   = 7;
  localparam int unsigned WINDOW_W   = 16;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 7'd3;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 16'd500;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_WINDOW    = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    CLICK_NONE   = 2'd0,
    CLICK_SINGLE = 2'd1,
    CLICK_DOUBLE = 2'd2,
    CLICK_TRIPLE = 2'd3
  } click_t;

  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_RESET = 3'd1,
    GEST_RIGHT = 3'd2,
    GEST_LEFT  = 3'd3,
    GEST_UP    = 3'd4,
    GEST_DONE  = 3'd5
  } gesture_t;

  typedef enum logic [3:0] {
    STAGE_IDLE  = 4'b0001,
    STAGE_RIGHT = 4'b0010,
    STAGE_LEFT  = 4'b0100,
    STAGE_UP    = 4'b1000
  } stage_t;

  typedef enum logic [2:0] {
    POS_HEADER = 3'b001,
    POS_SECOND = 3'b010,
    POS_THIRD  = 3'b100
  } byte_pos_t;

  // one assembled packet, as handed from front to back
  typedef struct packed {
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic              right;
    logic [31:0]       time_ms;
  } packet_t;

endpackage

### src/smgd_front.sv
// smgd_front: byte framing and packet assembly.
// Depends on smgd_pkg; feeds smgd_queue.
module smgd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  input  logic [31:0]          time_ms,
  input  logic                 queue_full,
  output logic                 push,
  output smgd_pkg::packet_t    push_packet
);

  smgd_pkg::byte_pos_t byte_pos;
  logic [7:0]          header_byte;
  logic [7:0]          second_byte;
  logic                accept;
  logic [7:0]          x_hi;
  logic [7:0]          y_hi;
  logic [7:0]          x_lo;
  logic [7:0]          y_lo;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (byte_pos == smgd_pkg::POS_THIRD);

  assign x_hi = header_byte & smgd_pkg::X_HI_MASK;
  assign y_hi = header_byte & smgd_pkg::Y_HI_MASK;
  assign x_lo = second_byte & smgd_pkg::LOW6_MASK;
  assign y_lo = rx_byte & smgd_pkg::LOW6_MASK;

  always_comb begin
    push_packet.delta_x = $signed((x_hi << 6) | x_lo);
    push_packet.delta_y = $signed((y_hi << 4) | y_lo);
    push_packet.right   = (header_byte & smgd_pkg::RIGHT_MASK) != 8'h00;
    push_packet.time_ms = time_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= smgd_pkg::POS_HEADER;
    end else if (accept) begin
      case (byte_pos)
        smgd_pkg::POS_HEADER: begin
          // resync: anything without the sync bit is dropped
          if ((rx_byte & smgd_pkg::SYNC_BIT) != 8'h00) begin
            byte_pos <= smgd_pkg::POS_SECOND;
          end
        end
        smgd_pkg::POS_SECOND: begin
          byte_pos <= smgd_pkg::POS_THIRD;
        end
        default: begin
          byte_pos <= smgd_pkg::POS_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_pos == smgd_pkg::POS_HEADER) begin
      header_byte <= rx_byte;
    end
    if (accept && byte_pos == smgd_pkg::POS_SECOND) begin
      second_byte <= rx_byte;
    end
  end

endmodule

### src/smgd_queue.sv
// smgd_queue: short packet FIFO between front and back.
// Depends on smgd_pkg for the packet type.
module smgd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  smgd_pkg::packet_t push_packet,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output smgd_pkg::packet_t head_packet
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  smgd_pkg::packet_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full        = (count == FULL_CNT);
  assign head_valid  = (count != '0);
  assign head_packet = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_packet;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

endmodule

### src/smgd_back.sv
// smgd_back: click and gesture tracking, configuration registers and output register.
// Depends on smgd_pkg; consumes packets from smgd_queue.
module smgd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [smgd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          head_valid,
  input  smgd_pkg::packet_t             head_packet,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [7:0]             delta_x,
  output logic signed [7:0]             delta_y,
  output logic                          right_pressed,
  output logic [1:0]                    click_event,
  output logic [2:0]                    gesture_event
);

  logic [smgd_pkg::THRESH_W-1:0] move_threshold;
  logic [smgd_pkg::WINDOW_W-1:0] click_window_ms;

  smgd_pkg::stage_t   stage;
  smgd_pkg::stage_t   stage_next;
  smgd_pkg::gesture_t gesture_next;
  logic [1:0]         press_count;
  logic [1:0]         click_count;
  logic [1:0]         click_next;
  logic [31:0]        last_press_time;
  logic               right_was_pressed;
  logic [31:0]        gap;
  logic               rise;
  logic signed [8:0]  thr_pos;
  logic signed [8:0]  thr_neg;
  logic signed [8:0]  dx_ext;
  logic signed [8:0]  dy_ext;

  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold  <= smgd_pkg::THRESHOLD_RESET;
      click_window_ms <= smgd_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      case (smgd_pkg::cfg_index_t'(cfg_index))
        smgd_pkg::CFG_THRESHOLD: move_threshold  <= cfg_data[smgd_pkg::THRESH_W-1:0];
        smgd_pkg::CFG_WINDOW:    click_window_ms <= cfg_data[smgd_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // click run: wrapped difference, negative means inside the window
  assign rise = head_packet.right && !right_was_pressed;
  assign gap  = head_packet.time_ms - last_press_time - {16'h0000, click_window_ms};
  assign click_count = gap[31] ? press_count + 2'd1 : 2'd1;
  assign click_next  = rise ? click_count : smgd_pkg::CLICK_NONE;

  assign thr_pos = $signed({2'b00, move_threshold});
  assign thr_neg = -thr_pos;
  assign dx_ext  = 9'(head_packet.delta_x);
  assign dy_ext  = 9'(head_packet.delta_y);

  always_comb begin
    stage_next   = stage;
    gesture_next = smgd_pkg::GEST_NONE;
    if (!head_packet.right) begin
      stage_next = smgd_pkg::STAGE_IDLE;
      if (stage != smgd_pkg::STAGE_IDLE) begin
        gesture_next = smgd_pkg::GEST_RESET;
      end
    end else begin
      case (stage)
        smgd_pkg::STAGE_IDLE: begin
          if (dx_ext > thr_pos) begin
            stage_next   = smgd_pkg::STAGE_RIGHT;
            gesture_next = smgd_pkg::GEST_RIGHT;
          end
        end
        smgd_pkg::STAGE_RIGHT: begin
          if (dx_ext < thr_neg) begin
            stage_next   = smgd_pkg::STAGE_LEFT;
            gesture_next = smgd_pkg::GEST_LEFT;
          end
        end
        smgd_pkg::STAGE_LEFT: begin
          if (dy_ext < thr_neg) begin
            stage_next   = smgd_pkg::STAGE_UP;
            gesture_next = smgd_pkg::GEST_UP;
          end
        end
        smgd_pkg::STAGE_UP: begin
          if (dy_ext > thr_pos) begin
            stage_next   = smgd_pkg::STAGE_IDLE;
            gesture_next = smgd_pkg::GEST_DONE;
          end
        end
        default: begin
          stage_next = smgd_pkg::STAGE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage             <= smgd_pkg::STAGE_IDLE;
      press_count       <= 2'd0;
      last_press_time   <= 32'd0;
      right_was_pressed <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (pop) begin
        stage             <= stage_next;
        right_was_pressed <= head_packet.right;
        if (rise) begin
          last_press_time <= head_packet.time_ms;
          press_count     <= (click_count == smgd_pkg::CLICK_TRIPLE) ? 2'd0 : click_count;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      delta_x       <= head_packet.delta_x;
      delta_y       <= head_packet.delta_y;
      right_pressed <= head_packet.right;
      click_event   <= click_next;
      gesture_event <= gesture_next;
    end
  end

  a_triple_wraps: assert property (@(posedge clk) disable iff (rst)
      pop && click_next == smgd_pkg::CLICK_TRIPLE |=> press_count == 2'd0)
    else $error("press count not cleared after triple press");
  a_release_idle: assert property (@(posedge clk) disable iff (rst)
      pop && !head_packet.right |=> stage == smgd_pkg::STAGE_IDLE)
    else $error("gesture stage not idle after release");
  a_release_event: assert property (@(posedge clk) disable iff (rst)
      pop && !head_packet.right |=>
        gesture_event == smgd_pkg::GEST_NONE || gesture_event == smgd_pkg::GEST_RESET)
    else $error("gesture step reported with button released");

endmodule

### src/serial_mouse_gesture_decoder_core.sv
// serial_mouse_gesture_decoder_core: top level of the serial mouse decoder.
// Instantiates smgd_front, smgd_queue and smgd_back; types from smgd_pkg.
//
//   channel | handshake                  | payload
//   --------+----------------------------+---------------------------------------------
//   in      | in_valid / in_stall        | rx_byte, time_ms
//   out     | out_valid / out_stall      | delta_x, delta_y, right_pressed,
//           |                            | click_event, gesture_event
//   cfg     | cfg_we (write only)        | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; a packet's result appears in the cycle after it
// leaves the packet queue, so from its third byte it passes through a queue entry and the output register.
// in_stall rises only when the packet queue is full; out_stall holds the output register.
// Reset (rst, synchronous) clears framing, queue, click and gesture state,
// and loads threshold 3 and window 500 ms.
module serial_mouse_gesture_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [smgd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  input  logic [31:0]                   time_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [7:0]             delta_x,
  output logic signed [7:0]             delta_y,
  output logic                          right_pressed,
  output logic [1:0]                    click_event,
  output logic [2:0]                    gesture_event
);

  logic              queue_full;
  logic              push;
  logic              pop;
  logic              head_valid;
  smgd_pkg::packet_t push_packet;
  smgd_pkg::packet_t head_packet;

  smgd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .time_ms     (time_ms),
    .queue_full  (queue_full),
    .push        (push),
    .push_packet (push_packet)
  );

  smgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_packet (push_packet),
    .full        (queue_full),
    .pop         (pop),
    .head_valid  (head_valid),
    .head_packet (head_packet)
  );

  smgd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .head_valid    (head_valid),
    .head_packet   (head_packet),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .right_pressed (right_pressed),
    .click_event   (click_event),
    .gesture_event (gesture_event)
  );

endmodule

### dv/smgd_check_pkg.sv
// smgd_check_pkg: expected-report predictor and scoreboard for the serial mouse decoder bench.
// Depends on smgd_pkg for the masks and the click and gesture codes.
package smgd_check_pkg;

  typedef enum logic [2:0] {
    AWAIT_HEADER = 3'b001,
    AWAIT_SECOND = 3'b010,
    AWAIT_THIRD  = 3'b100
  } frame_pos_t;

  typedef enum logic [3:0] {
    STEP_IDLE        = 4'b0001,
    STEP_AFTER_RIGHT = 4'b0010,
    STEP_AFTER_LEFT  = 4'b0100,
    STEP_AFTER_UP    = 4'b1000
  } gesture_step_t;

  typedef struct packed {
    logic signed [7:0]  delta_x;
    logic signed [7:0]  delta_y;
    logic               right;
    smgd_pkg::click_t   click;
    smgd_pkg::gesture_t gesture;
  } mouse_report_t;

  class mouse_report_checker;
    logic [smgd_pkg::THRESH_W-1:0] threshold;
    logic [smgd_pkg::WINDOW_W-1:0] window;
    frame_pos_t          pos;
    logic [7:0]          header_byte;
    logic [7:0]          second_byte;
    gesture_step_t       step;
    logic [1:0]          press_count;
    logic [31:0]         last_press;
    bit                  right_prev;
    mouse_report_t       pending_reports[$];
    int unsigned         mismatches;
    int unsigned         checked;

    function new();
      threshold   = smgd_pkg::THRESHOLD_RESET;
      window      = smgd_pkg::WINDOW_RESET;
      pos         = AWAIT_HEADER;
      header_byte = '0;
      second_byte = '0;
      step        = STEP_IDLE;
      press_count = '0;
      last_press  = '0;
      right_prev  = 1'b0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void write_reg(smgd_pkg::cfg_index_t idx,
                            logic [smgd_pkg::CFG_DATA_W-1:0] value);
      if (idx == smgd_pkg::CFG_THRESHOLD) begin
        threshold = value[smgd_pkg::THRESH_W-1:0];
      end else begin
        window = value[smgd_pkg::WINDOW_W-1:0];
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    // one accepted input transaction
    function void note_byte(logic [7:0] rx, logic [31:0] now);
      mouse_report_t rep;
      logic [7:0]    xr;
      logic [7:0]    yr;
      logic [31:0]   diff;
      int            dx;
      int            dy;
      int            t;
      bit            right;
      case (pos)
        AWAIT_HEADER: begin
          if ((rx & smgd_pkg::SYNC_BIT) != 8'h00) begin
            header_byte = rx;
            pos = AWAIT_SECOND;
          end
        end
        AWAIT_SECOND: begin
          second_byte = rx;
          pos = AWAIT_THIRD;
        end
        default: begin
          pos   = AWAIT_HEADER;
          xr    = ((header_byte & smgd_pkg::X_HI_MASK) << 6)
                | (second_byte & smgd_pkg::LOW6_MASK);
          yr    = ((header_byte & smgd_pkg::Y_HI_MASK) << 4)
                | (rx & smgd_pkg::LOW6_MASK);
          dx    = int'($signed(xr));
          dy    = int'($signed(yr));
          t     = int'(threshold);
          right = (header_byte & smgd_pkg::RIGHT_MASK) != 8'h00;
          rep.click   = smgd_pkg::CLICK_NONE;
          rep.gesture = smgd_pkg::GEST_NONE;
          if (right && !right_prev) begin
            diff = now - last_press - {16'b0, window};
            if (diff[31]) begin
              press_count = press_count + 2'd1;
            end else begin
              press_count = 2'd1;
            end
            last_press = now;
            rep.click = smgd_pkg::click_t'(press_count);
            if (press_count == 2'd3) press_count = 2'd0;
          end
          right_prev = right;
          if (!right) begin
            if (step != STEP_IDLE) rep.gesture = smgd_pkg::GEST_RESET;
            step = STEP_IDLE;
          end else if (step == STEP_IDLE && dx > t) begin
            step = STEP_AFTER_RIGHT;
            rep.gesture = smgd_pkg::GEST_RIGHT;
          end else if (step == STEP_AFTER_RIGHT && dx < -t) begin
            step = STEP_AFTER_LEFT;
            rep.gesture = smgd_pkg::GEST_LEFT;
          end else if (step == STEP_AFTER_LEFT && dy < -t) begin
            step = STEP_AFTER_UP;
            rep.gesture = smgd_pkg::GEST_UP;
          end else if (step == STEP_AFTER_UP && dy > t) begin
            step = STEP_IDLE;
            rep.gesture = smgd_pkg::GEST_DONE;
          end
          rep.delta_x = xr;
          rep.delta_y = yr;
          rep.right   = right;
          pending_reports.push_back(rep);
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // one accepted output transaction
    task check_result(mouse_report_t got);
      mouse_report_t exp;
      if (pending_reports.size() == 0) begin
        report("report with none expected");
      end else begin
        exp = pending_reports.pop_front();
        checked++;
        if (got.delta_x !== exp.delta_x)
          report($sformatf("delta_x %0d, expected %0d", got.delta_x, exp.delta_x));
        if (got.delta_y !== exp.delta_y)
          report($sformatf("delta_y %0d, expected %0d", got.delta_y, exp.delta_y));
        if (got.right !== exp.right)
          report($sformatf("right_pressed %0d, expected %0d", got.right, exp.right));
        if (got.click !== exp.click)
          report($sformatf("click_event %0d, expected %0d", got.click, exp.click));
        if (got.gesture !== exp.gesture)
          report($sformatf("gesture_event %0d, expected %0d", got.gesture, exp.gesture));
      end
    endtask
  endclass

endpackage

### dv/serial_mouse_gesture_decoder_core_tb.sv
// serial_mouse_gesture_decoder_core_tb: self-checking bench for the serial mouse decoder core.
// Directed packets, then random gesture walks, click runs and noise under several settings.
// Depends on smgd_pkg, smgd_check_pkg and serial_mouse_gesture_decoder_core.
module serial_mouse_gesture_decoder_core_tb;

  localparam int HOLD_CYCLES = 200;
  localparam int PHASES      = 6;
  localparam int PHASE_BYTES = 320;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic                            cfg_index;
  logic [smgd_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [7:0]                      rx_byte;
  logic [31:0]                     time_ms;
  logic                            out_valid;
  logic                            out_stall;
  logic signed [7:0]               delta_x;
  logic signed [7:0]               delta_y;
  logic                            right_pressed;
  logic [1:0]                      click_event;
  logic [2:0]                      gesture_event;

  smgd_check_pkg::mouse_report_checker board;
  int                              thr_now;
  logic [smgd_pkg::WINDOW_W-1:0]   window_now;
  logic [31:0]                     clock_ms;
  bit                              tx_burst;
  bit                              rx_burst;
  bit                              hold_request;
  int unsigned                     bytes_sent;
  int unsigned                     settings_used;

  serial_mouse_gesture_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .time_ms       (time_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .right_pressed (right_pressed),
    .click_event   (click_event),
    .gesture_event (gesture_event)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("serial_mouse_gesture_decoder_core verification failed");
    $finish;
  end

  task automatic write_reg(smgd_pkg::cfg_index_t idx, logic [smgd_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic [31:0] t);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    time_ms  <= t;
    do @(posedge clk); while (in_stall);
    board.note_byte(b, t);
    bytes_sent++;
  endtask

  task automatic send_packet(logic signed [7:0] dx, logic signed [7:0] dy, bit right,
                             logic [31:0] t3);
    logic [7:0] hdr;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] noise;
    noise = 8'($urandom);
    hdr = smgd_pkg::SYNC_BIT | (noise & 8'hA0) | {4'b0000, dy[7:6], dx[7:6]};
    if (right) hdr = hdr | smgd_pkg::RIGHT_MASK;
    b2 = {noise[3:2], dx[5:0]};
    b3 = {noise[1:0], dy[5:0]};
    send_byte(hdr, $urandom);
    send_byte(b2, $urandom);
    send_byte(b3, t3);
    clock_ms = t3;
  endtask

  // presses land around the window edge relative to the previous press
  function automatic logic [31:0] packet_time(bit right);
    logic [31:0] gap;
    if ($urandom_range(0, 7) == 0) return $urandom;
    if (!(right && !board.right_prev)) return clock_ms + $urandom_range(0, 5);
    case ($urandom_range(0, 5))
      0:       gap = window_now - 1;
      1:       gap = 32'(window_now);
      2:       gap = window_now + 1;
      3:       gap = $urandom_range(0, 40);
      4:       gap = $urandom_range(0, 2 * window_now + 2);
      default: gap = $urandom;
    endcase
    return board.last_press + gap;
  endfunction

  function automatic logic [7:0] pick_move(bit positive);
    int mag;
    case ($urandom_range(0, 4))
      0:       mag = thr_now;
      1:       mag = thr_now + 1;
      default: mag = $urandom_range(thr_now, positive ? 127 : 128);
    endcase
    if (positive && mag > 127) mag = 127;
    return positive ? 8'(mag) : 8'(-mag);
  endfunction

  task automatic gesture_walk();
    int         steps;
    logic [7:0] dx;
    logic [7:0] dy;
    steps = $urandom_range(1, 4);
    for (int s = 0; s < steps; s++) begin
      if ($urandom_range(0, 4) == 0)
        send_packet(8'($urandom), 8'($urandom), 1'b1, packet_time(1'b1));
      dx = 8'($urandom);
      dy = 8'($urandom);
      case (s)
        0:       dx = pick_move(1'b1);
        1:       dx = pick_move(1'b0);
        2:       dy = pick_move(1'b0);
        default: dy = pick_move(1'b1);
      endcase
      send_packet(dx, dy, 1'b1, packet_time(1'b1));
    end
    if ($urandom_range(0, 3) != 0)
      send_packet(8'($urandom), 8'($urandom), 1'b0, packet_time(1'b0));
  endtask

  // let outstanding reports come back, then allow for bytes still in flight
  task automatic drain();
    for (int i = 0; i < 5000 && board.pending() != 0; i++) @(posedge clk);
    if (board.pending() != 0) begin
      board.report($sformatf("%0d reports never arrived", board.pending()));
      board.pending_reports.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic settle();
    while (board.pos != smgd_check_pkg::AWAIT_HEADER) send_byte(8'($urandom), $urandom);
    in_valid <= 1'b0;
    drain();
  endtask

  task automatic apply_setting(int p);
    logic [8:0] upper;
    upper = 9'($urandom);
    case (p)
      0: begin thr_now = 0;   window_now = 16'hFFFF; end
      1: begin thr_now = 127; window_now = 16'd1;    end
      2: begin thr_now = 3;   window_now = 16'd500;  end
      3: begin thr_now = $urandom_range(0, 127); window_now = 16'd0; end
      4: begin
        thr_now    = $urandom_range(0, 20);
        window_now = 16'($urandom_range(1, 65535));
      end
      default: begin
        thr_now    = $urandom_range(0, 127);
        window_now = 16'($urandom_range(1, 65535));
      end
    endcase
    write_reg(smgd_pkg::CFG_THRESHOLD, {upper, 7'(thr_now)});
    write_reg(smgd_pkg::CFG_WINDOW, window_now);
    settings_used++;
  endtask

  task automatic run_phase();
    int unsigned stop_at;
    stop_at = bytes_sent + PHASE_BYTES;
    while (bytes_sent < stop_at) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gesture_walk();
        6, 7: begin
          repeat ($urandom_range(1, 4)) begin
            send_packet(8'($urandom), 8'($urandom), 1'b1, packet_time(1'b1));
            send_packet(8'($urandom), 8'($urandom), 1'b0, packet_time(1'b0));
          end
        end
        8: begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom);
          if ($urandom_range(0, 1) == 0) begin
            while (board.pos != smgd_check_pkg::AWAIT_HEADER)
              send_byte(8'($urandom), $urandom);
          end
        end
        default: begin
          send_packet(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), $urandom);
        end
      endcase
    end
  endtask

  // output side: random stall before each report, one long hold-off on request
  initial begin
    int unsigned                   stall_cycles;
    smgd_check_pkg::mouse_report_t got;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall_cycles = rx_burst ? 0 : $urandom_range(0, 8);
      if (stall_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.delta_x = delta_x;
      got.delta_y = delta_y;
      got.right   = right_pressed;
      got.click   = smgd_pkg::click_t'(click_event);
      got.gesture = smgd_pkg::gesture_t'(gesture_event);
      board.check_result(got);
    end
  end

  initial begin
    board         = new();
    thr_now       = int'(smgd_pkg::THRESHOLD_RESET);
    window_now    = smgd_pkg::WINDOW_RESET;
    clock_ms      = '0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    hold_request  = 1'b0;
    bytes_sent    = 0;
    settings_used = 1;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= smgd_pkg::CFG_THRESHOLD;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    rx_byte   <= '0;
    time_ms   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: dropped headers, full gesture, release with and without reset,
    // single, double and triple press
    send_byte(8'h00, 32'h0000_0000);
    send_byte(8'hBF, 32'hFFFF_FFFF);
    send_packet(8'sd127, -8'sd128, 1'b1, 32'd1000);
    send_packet(-8'sd128, 8'sd127, 1'b1, 32'd1100);
    send_packet(8'sd0, -8'sd4, 1'b1, 32'd1150);
    send_packet(8'sd5, 8'sd3, 1'b1, 32'd1160);
    send_packet(8'sd0, 8'sd4, 1'b1, 32'd1170);
    send_packet(8'sd0, 8'sd0, 1'b0, 32'd1180);
    send_packet(8'sd4, 8'sd0, 1'b1, 32'd1200);
    send_packet(8'sd0, 8'sd0, 1'b0, 32'd1250);
    send_packet(8'sd0, 8'sd0, 1'b1, 32'd1300);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      apply_setting(p);
      if (p == 2) hold_request = 1'b1;
      run_phase();
      settle();
    end
    repeat (20) @(posedge clk);

    $display("%0d bytes sent, %0d reports checked under %0d register settings",
             bytes_sent, board.checked, settings_used);
    $display("gesture walks, click runs around the window edge, noise and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (board.mismatches == 0) begin
      $display("serial_mouse_gesture_decoder_core verification clean");
    end else begin
      $display("serial_mouse_gesture_decoder_core verification failed");
    end
    $finish;
  end

endmodule

### serial_mouse_gesture_decoder_core.f
src/smgd_pkg.sv
src/smgd_front.sv
src/smgd_queue.sv
src/smgd_back.sv
src/serial_mouse_gesture_decoder_core.sv
dv/smgd_check_pkg.sv
dv/serial_mouse_gesture_decoder_core_tb.sv
